>>> hdl/sorted_unique_set_table_assert.svh
// Assertion macros used by the sorted unique set table RTL.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef SORTED_UNIQUE_SET_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_SET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_unique_set_table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SUTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_unique_set_table: next-cycle check failed");

`endif

>>> hdl/suts_pkg.sv
// Package for the sorted unique set table: sizes and the cell interface types.
// Used by suts_cell, suts_enc and sorted_unique_set_table; depends on nothing.
`timescale 1ns / 1ps

package suts_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IN_KEY_W  = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 7;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic                 shift_en;
    logic [KEY_WIDTH-1:0] key;
  } cell_bcast_t;

  typedef struct packed {
    logic lt;
    logic hit;
  } cell_stat_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
  } enc_res_t;

endpackage

>>> hdl/sorted_unique_set_table.sv
// Sorted unique set table: a request is taken when start is high and busy is low,
// one request per clock. The request is registered in req_vld_r, the result strobe
// in out_strobe_r from req_vld_r; the strobe stays for one cycle and the result
// cannot be held off. Every slot compares its key with the request key in the same
// cycle, and on an insert the larger keys move up one slot in that cycle, so the row
// of cells sets the one-request-per-clock rate. busy is high during reset and in the
// cycle that follows it. Depends on suts_pkg, suts_cell and suts_enc.
`timescale 1ns / 1ps
`include "sorted_unique_set_table_assert.svh"

module sorted_unique_set_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [suts_pkg::IN_KEY_W-1:0] in_key_value,
  output logic                          out_strobe,
  output logic [suts_pkg::POS_W-1:0]    out_position,
  output logic                          out_found,
  output logic                          out_dropped,
  output logic [suts_pkg::POS_W-1:0]    out_entry_count
);

  logic                           busy_r;
  logic                           req_vld_r;
  logic                           req_mode_r;
  logic [suts_pkg::KEY_WIDTH-1:0] req_key_r;
  logic [suts_pkg::CNT_W-1:0]     key_count_r;
  logic [suts_pkg::CNT_W-1:0]     key_count_nxt;
  logic                           out_strobe_r;
  logic [suts_pkg::POS_W-1:0]     out_position_r;
  logic                           out_found_r;
  logic                           out_dropped_r;
  logic [suts_pkg::POS_W-1:0]     out_entry_count_r;

  logic                           accept;
  logic                           is_insert;
  logic                           has_room;
  logic                           insert_do;
  logic                           drop_do;
  suts_pkg::cell_bcast_t          bcast;
  suts_pkg::enc_res_t             enc_res;
  logic [suts_pkg::CAPACITY-1:0]  lt_vec;
  logic [suts_pkg::CAPACITY-1:0]  hit_vec;
  logic [suts_pkg::KEY_WIDTH-1:0] keys_q [suts_pkg::CAPACITY];

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign is_insert = req_vld_r && (req_mode_r == suts_pkg::MODE_INSERT);
  assign has_room  = key_count_r < suts_pkg::CNT_W'(suts_pkg::CAPACITY);
  assign insert_do = is_insert && !enc_res.found && has_room;
  assign drop_do   = is_insert && !enc_res.found && !has_room;

  assign bcast.shift_en = insert_do;
  assign bcast.key      = req_key_r;

  assign key_count_nxt = insert_do ? key_count_r + suts_pkg::CNT_W'(1) : key_count_r;

  for (genvar i = 0; i < suts_pkg::CAPACITY; i++) begin : g_cell
    suts_pkg::cell_stat_t stat;

    suts_cell u_cell (
      .clk      (clk),
      .bcast    (bcast),
      .occ      (suts_pkg::CNT_W'(i) < key_count_r),
      .left_lt  ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
      .left_key (keys_q[(i == 0) ? 0 : i - 1]),
      .stat     (stat),
      .key_q    (keys_q[i])
    );

    assign lt_vec[i]  = stat.lt;
    assign hit_vec[i] = stat.hit;
  end

  suts_enc u_enc (
    .lt_vec  (lt_vec),
    .hit_vec (hit_vec),
    .res     (enc_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      req_vld_r    <= 1'b0;
      key_count_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      req_vld_r    <= accept;
      key_count_r  <= key_count_nxt;
      out_strobe_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r <= in_mode;
      req_key_r  <= in_key_value[suts_pkg::KEY_WIDTH-1:0];
    end
    if (req_vld_r) begin
      out_position_r    <= suts_pkg::POS_W'(enc_res.position);
      out_found_r       <= enc_res.found;
      out_dropped_r     <= drop_do;
      out_entry_count_r <= suts_pkg::POS_W'(key_count_nxt);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_position    = out_position_r;
  assign out_found       = out_found_r;
  assign out_dropped     = out_dropped_r;
  assign out_entry_count = out_entry_count_r;

  `SUTS_ASSERT_IMP(a_count_bound, 1'b1, key_count_r <= suts_pkg::CNT_W'(suts_pkg::CAPACITY))
  `SUTS_ASSERT_IMP(a_pos_bound, req_vld_r, enc_res.position <= key_count_r)
  `SUTS_ASSERT_NXT(a_result_follows, req_vld_r, out_strobe_r)
  `SUTS_ASSERT_IMP(a_found_excl, out_strobe_r, !(out_found_r && out_dropped_r))
  `SUTS_ASSERT_NXT(a_count_grow, insert_do, key_count_r == $past(key_count_r) + suts_pkg::CNT_W'(1))
  `SUTS_ASSERT_NXT(a_count_hold, !insert_do, $stable(key_count_r))

endmodule

>>> hdl/suts_cell.sv
// One slot of the sorted key row: holds a key, compares it with the request key
// and takes its left neighbor's key or the request key on an insert. Uses suts_pkg.
`timescale 1ns / 1ps

module suts_cell (
  input  logic                          clk,
  input  suts_pkg::cell_bcast_t         bcast,
  input  logic                          occ,
  input  logic                          left_lt,
  input  logic [suts_pkg::KEY_WIDTH-1:0] left_key,
  output suts_pkg::cell_stat_t          stat,
  output logic [suts_pkg::KEY_WIDTH-1:0] key_q
);

  logic [suts_pkg::KEY_WIDTH-1:0] key_r;
  logic [suts_pkg::KEY_WIDTH-1:0] key_nxt;
  logic                           lt;

  assign lt       = occ && (key_r < bcast.key);
  assign stat.lt  = lt;
  assign stat.hit = occ && (key_r == bcast.key);
  assign key_q    = key_r;
  assign key_nxt  = left_lt ? bcast.key : left_key;

  always_ff @(posedge clk) begin
    if (bcast.shift_en && !lt) begin
      key_r <= key_nxt;
    end
  end

endmodule

>>> hdl/suts_enc.sv
// Turns the row's less-than and hit flags into the lower-bound position and
// the found flag. Uses suts_pkg.
`timescale 1ns / 1ps

module suts_enc (
  input  logic [suts_pkg::CAPACITY-1:0] lt_vec,
  input  logic [suts_pkg::CAPACITY-1:0] hit_vec,
  output suts_pkg::enc_res_t            res
);

  logic [suts_pkg::CAPACITY:0] boundary;

  always_comb begin
    boundary[0] = !lt_vec[0];
    for (int i = 1; i < suts_pkg::CAPACITY; i++) begin
      boundary[i] = lt_vec[i-1] && !lt_vec[i];
    end
    boundary[suts_pkg::CAPACITY] = lt_vec[suts_pkg::CAPACITY-1];
  end

  always_comb begin
    res = '0;
    for (int i = 0; i <= suts_pkg::CAPACITY; i++) begin
      if (boundary[i]) begin
        res.position = res.position | suts_pkg::CNT_W'(i);
      end
    end
    for (int i = 0; i < suts_pkg::CAPACITY; i++) begin
      res.found = res.found | (boundary[i] && hit_vec[i]);
    end
  end

endmodule
